### rtl/i2cram_pkg.sv
package i2cram_pkg;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd104;

    localparam logic [2:0] K_END   = 3'd0;
    localparam logic [2:0] K_START = 3'd1;
    localparam logic [2:0] K_TXDW  = 3'd2;
    localparam logic [2:0] K_TXDR  = 3'd3;
    localparam logic [2:0] K_TXREG = 3'd4;
    localparam logic [2:0] K_TXDAT = 3'd5;
    localparam logic [2:0] K_RX    = 3'd6;
    localparam logic [2:0] K_STOP  = 3'd7;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_CLK_LOW   = 3'd1;
    localparam logic [2:0] ERR_DATA_LOW  = 3'd2;
    localparam logic [2:0] ERR_NO_ACK    = 3'd3;
    localparam logic [2:0] ERR_STOP_DATA = 3'd4;

    localparam logic [2:0] PL_NONE       = 3'd0;
    localparam logic [2:0] PL_STOP_CLK   = 3'd1;
    localparam logic [2:0] PL_STOP_DATA  = 3'd2;
    localparam logic [2:0] PL_BITIN_CLK  = 3'd3;
    localparam logic [2:0] PL_BITOUT_DAT = 3'd4;
    localparam logic [2:0] PL_BITOUT_CLK = 3'd5;
    localparam logic [2:0] PL_ACK        = 3'd6;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_READ  = 1'b1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       start_request;
        logic       operation;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       scl_level;
        logic       sda_level;
    } req_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [2:0] error_code;
        logic [2:0] error_place;
    } res_t;

    function automatic logic [2:0] kind_at(input logic op, input logic [3:0] idx);
        logic [2:0] k;
        case (idx)
            4'd1:    k = K_START;
            4'd2:    k = K_TXDW;
            4'd3:    k = K_TXREG;
            4'd4:    k = (op == OP_READ) ? K_STOP  : K_TXDAT;
            4'd5:    k = (op == OP_READ) ? K_START : K_STOP;
            4'd6:    k = (op == OP_READ) ? K_TXDR  : K_END;
            4'd7:    k = (op == OP_READ) ? K_RX    : K_END;
            4'd8:    k = (op == OP_READ) ? K_STOP  : K_END;
            default: k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic is_tx(input logic [2:0] k);
        return (k == K_TXDW) || (k == K_TXDR) || (k == K_TXREG) || (k == K_TXDAT);
    endfunction

endpackage

### rtl/i2cram_if.sv
interface i2cram_req_if;
    logic       valid;
    logic       ready;
    logic       start_request;
    logic       operation;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic       scl_level;
    logic       sda_level;

    modport source (
        output valid, start_request, operation, reg_address, write_data,
               scl_level, sda_level,
        input  ready
    );
    modport sink (
        input  valid, start_request, operation, reg_address, write_data,
               scl_level, sda_level,
        output ready
    );
endinterface

interface i2cram_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [2:0] error_code;
    logic [2:0] error_place;

    modport source (
        output valid, scl_out, sda_out, busy_res, done_res, read_data,
               error_code, error_place,
        input  ready
    );
    modport sink (
        input  valid, scl_out, sda_out, busy_res, done_res, read_data,
               error_code, error_place,
        output ready
    );
endinterface

### rtl/i2cram_seq.sv
module i2cram_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [6:0]          device_address,
    input  i2cram_pkg::req_t    req,
    output i2cram_pkg::res_t    res
);

    logic [3:0] seg_reg,    seg_next;
    logic [2:0] phase_reg,  phase_next;
    logic [3:0] bit_reg,    bit_next;
    logic [7:0] shift_reg,  shift_next;
    logic       lop_reg,    lop_next;
    logic [7:0] lreg_reg,   lreg_next;
    logic [7:0] ldat_reg,   ldat_next;
    logic [7:0] rx_reg,     rx_next;
    logic [2:0] ecode_reg,  ecode_next;
    logic [2:0] eplace_reg, eplace_next;

    logic [2:0] kind_cur;
    logic [2:0] kind_new;
    logic [2:0] kind_out;
    logic [3:0] seg_inc;
    logic [2:0] phase_inc;
    logic [2:0] phase_cnt;
    logic [3:0] bit_inc;
    logic       leave;
    logic [1:0] p;

    always_comb
    begin
        seg_next    = seg_reg;
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        lop_next    = lop_reg;
        lreg_next   = lreg_reg;
        ldat_next   = ldat_reg;
        rx_next     = rx_reg;
        ecode_next  = ecode_reg;
        eplace_next = eplace_reg;
        leave       = 1'b0;
        kind_cur    = i2cram_pkg::kind_at(lop_reg, seg_reg);
        seg_inc     = seg_reg + 4'd1;
        kind_new    = i2cram_pkg::kind_at(lop_reg, seg_inc);
        phase_inc   = phase_reg + 3'd1;
        bit_inc     = bit_reg + 4'd1;

        if (i2cram_pkg::is_tx(kind_cur))
        begin
            phase_cnt = (bit_reg < i2cram_pkg::BITS_PER_BYTE) ? 3'd3 : 3'd2;
        end
        else if (kind_cur == i2cram_pkg::K_RX)
        begin
            phase_cnt = (bit_reg < i2cram_pkg::BITS_PER_BYTE) ? 3'd2 : 3'd3;
        end
        else
        begin
            phase_cnt = 3'd4;
        end

        if (seg_reg != 4'd0)
        begin
            if (kind_cur == i2cram_pkg::K_END)
            begin
                seg_next = 4'd0;
            end
            else
            begin
                // Line checks on the levels sampled after the previous phase.
                if (kind_cur == i2cram_pkg::K_STOP)
                begin
                    if (phase_reg == 3'd1 && !req.scl_level &&
                        ecode_next == i2cram_pkg::ERR_NONE)
                    begin
                        ecode_next  = i2cram_pkg::ERR_CLK_LOW;
                        eplace_next = i2cram_pkg::PL_STOP_CLK;
                    end
                    if (phase_reg == 3'd2 && !req.sda_level &&
                        ecode_next == i2cram_pkg::ERR_NONE)
                    begin
                        ecode_next  = i2cram_pkg::ERR_STOP_DATA;
                        eplace_next = i2cram_pkg::PL_STOP_DATA;
                    end
                end
                else if (i2cram_pkg::is_tx(kind_cur))
                begin
                    if (bit_reg < i2cram_pkg::BITS_PER_BYTE)
                    begin
                        if (phase_reg == 3'd0 && shift_reg[7] && !req.sda_level &&
                            ecode_next == i2cram_pkg::ERR_NONE)
                        begin
                            ecode_next  = i2cram_pkg::ERR_DATA_LOW;
                            eplace_next = i2cram_pkg::PL_BITOUT_DAT;
                        end
                        if (phase_reg == 3'd1 && !req.scl_level &&
                            ecode_next == i2cram_pkg::ERR_NONE)
                        begin
                            ecode_next  = i2cram_pkg::ERR_CLK_LOW;
                            eplace_next = i2cram_pkg::PL_BITOUT_CLK;
                        end
                    end
                    else if (phase_reg == 3'd0)
                    begin
                        if (!req.scl_level && ecode_next == i2cram_pkg::ERR_NONE)
                        begin
                            ecode_next  = i2cram_pkg::ERR_CLK_LOW;
                            eplace_next = i2cram_pkg::PL_BITIN_CLK;
                        end
                        if (req.sda_level && ecode_next == i2cram_pkg::ERR_NONE)
                        begin
                            ecode_next  = i2cram_pkg::ERR_NO_ACK;
                            eplace_next = i2cram_pkg::PL_ACK;
                        end
                    end
                end
                else if (kind_cur == i2cram_pkg::K_RX)
                begin
                    if (bit_reg < i2cram_pkg::BITS_PER_BYTE)
                    begin
                        if (phase_reg == 3'd0)
                        begin
                            if (!req.scl_level && ecode_next == i2cram_pkg::ERR_NONE)
                            begin
                                ecode_next  = i2cram_pkg::ERR_CLK_LOW;
                                eplace_next = i2cram_pkg::PL_BITIN_CLK;
                            end
                            shift_next = {shift_reg[6:0], req.sda_level};
                        end
                    end
                    else
                    begin
                        if (phase_reg == 3'd0 && !req.sda_level &&
                            ecode_next == i2cram_pkg::ERR_NONE)
                        begin
                            ecode_next  = i2cram_pkg::ERR_DATA_LOW;
                            eplace_next = i2cram_pkg::PL_BITOUT_DAT;
                        end
                        if (phase_reg == 3'd1 && !req.scl_level &&
                            ecode_next == i2cram_pkg::ERR_NONE)
                        begin
                            ecode_next  = i2cram_pkg::ERR_CLK_LOW;
                            eplace_next = i2cram_pkg::PL_BITOUT_CLK;
                        end
                    end
                end

                // Step to the next phase, bit or segment.
                if (i2cram_pkg::is_tx(kind_cur) && bit_reg < i2cram_pkg::BITS_PER_BYTE &&
                    phase_reg == 3'd2)
                begin
                    shift_next = {shift_next[6:0], 1'b0};
                end
                if (phase_inc < phase_cnt)
                begin
                    phase_next = phase_inc;
                end
                else
                begin
                    phase_next = 3'd0;
                    if (i2cram_pkg::is_tx(kind_cur) || kind_cur == i2cram_pkg::K_RX)
                    begin
                        bit_next = bit_inc;
                        if (bit_inc > i2cram_pkg::BITS_PER_BYTE)
                        begin
                            leave = 1'b1;
                            if (kind_cur == i2cram_pkg::K_RX)
                            begin
                                rx_next = shift_next;
                            end
                        end
                    end
                    else
                    begin
                        leave = 1'b1;
                    end
                end

                if (leave)
                begin
                    seg_next   = seg_inc;
                    phase_next = 3'd0;
                    bit_next   = 4'd0;
                    case (kind_new)
                        i2cram_pkg::K_TXDW:  shift_next = {device_address, 1'b0};
                        i2cram_pkg::K_TXDR:  shift_next = {device_address, 1'b1};
                        i2cram_pkg::K_TXREG: shift_next = lreg_reg;
                        i2cram_pkg::K_TXDAT: shift_next = ldat_reg;
                        default:             shift_next = 8'd0;
                    endcase
                    if (kind_new == i2cram_pkg::K_END)
                    begin
                        seg_next = 4'd0;
                    end
                end
            end
        end

        if (seg_next == 4'd0 && req.start_request)
        begin
            lop_next    = req.operation;
            lreg_next   = req.reg_address;
            ldat_next   = req.write_data;
            ecode_next  = i2cram_pkg::ERR_NONE;
            eplace_next = i2cram_pkg::PL_NONE;
            seg_next    = 4'd1;
            phase_next  = 3'd0;
            bit_next    = 4'd0;
            shift_next  = 8'd0;
        end
    end

    always_comb
    begin
        kind_out        = i2cram_pkg::kind_at(lop_next, seg_next);
        p               = phase_next[1:0];
        res.scl_out     = 1'b1;
        res.sda_out     = 1'b1;
        res.busy_res    = 1'b0;
        res.done_res    = 1'b0;
        res.read_data   = rx_next;
        res.error_code  = ecode_next;
        res.error_place = eplace_next;
        if (seg_next != 4'd0)
        begin
            res.busy_res = 1'b1;
            res.done_res = (kind_out == i2cram_pkg::K_STOP) && (phase_next == 3'd3) &&
                           (i2cram_pkg::kind_at(lop_next, seg_next + 4'd1) ==
                            i2cram_pkg::K_END);
            case (kind_out)
                i2cram_pkg::K_START:
                begin
                    res.scl_out = (p != 2'd3);
                    res.sda_out = (p < 2'd2);
                end
                i2cram_pkg::K_STOP:
                begin
                    res.scl_out = (p == 2'd1) || (p == 2'd2);
                    res.sda_out = (p >= 2'd2);
                end
                i2cram_pkg::K_TXDW, i2cram_pkg::K_TXDR, i2cram_pkg::K_TXREG,
                i2cram_pkg::K_TXDAT:
                begin
                    if (bit_next < i2cram_pkg::BITS_PER_BYTE)
                    begin
                        res.scl_out = (p == 2'd1);
                        res.sda_out = shift_next[7];
                    end
                    else
                    begin
                        res.scl_out = (p == 2'd0);
                        res.sda_out = 1'b1;
                    end
                end
                i2cram_pkg::K_RX:
                begin
                    res.scl_out = (bit_next < i2cram_pkg::BITS_PER_BYTE) ? (p == 2'd0)
                                                                         : (p == 2'd1);
                    res.sda_out = 1'b1;
                end
                default:
                begin
                    res.scl_out = 1'b1;
                    res.sda_out = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg    <= 4'd0;
            phase_reg  <= 3'd0;
            bit_reg    <= 4'd0;
            shift_reg  <= 8'd0;
            lop_reg    <= 1'b0;
            lreg_reg   <= 8'd0;
            ldat_reg   <= 8'd0;
            rx_reg     <= 8'd0;
            ecode_reg  <= 3'd0;
            eplace_reg <= 3'd0;
        end
        else if (step_en)
        begin
            seg_reg    <= seg_next;
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            lop_reg    <= lop_next;
            lreg_reg   <= lreg_next;
            ldat_reg   <= ldat_next;
            rx_reg     <= rx_next;
            ecode_reg  <= ecode_next;
            eplace_reg <= eplace_next;
        end
    end

endmodule

### rtl/i2c_register_access_master.sv
// Single-register I2C master, stepped one bus phase per request.
// Each request on req is one phase tick: it carries the SCL and SDA levels
// sampled at the end of the previous phase and, while the block is idle, a
// start flag with the operation, register address and write data. Each
// request yields exactly one result on res: the line drives for the new
// phase, busy and done flags, the last byte read and the first fault seen.
// The device address is written through cfg_we and cfg_wdata; the user
// must write it only while idle, as the block does not enforce this. A
// request is registered in the input register on acceptance and its
// result in the result register; one request is taken in every cycle
// while the receiver does not stall; the phase sequencer steps once per
// request. On a stall the result register holds its item and req.ready
// falls once the input register is full. Reset clears the sequencer to
// idle, empties both registers and sets the device address to its default.
module i2c_register_access_master (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    i2cram_req_if.sink          req,
    i2cram_res_if.source        res
);

    logic                   in_valid_reg;
    i2cram_pkg::req_t       in_data_reg;
    logic                   out_valid_reg;
    i2cram_pkg::res_t       out_data_reg;
    logic [6:0]             dev_addr_reg;
    i2cram_pkg::res_t       step_res;
    logic                   adv;

    assign adv       = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= i2cram_pkg::DEV_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            dev_addr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_data_reg.start_request <= req.start_request;
            in_data_reg.operation     <= req.operation;
            in_data_reg.reg_address   <= req.reg_address;
            in_data_reg.write_data    <= req.write_data;
            in_data_reg.scl_level     <= req.scl_level;
            in_data_reg.sda_level     <= req.sda_level;
        end
        if (adv)
        begin
            out_data_reg <= step_res;
        end
    end

    i2cram_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (adv),
        .device_address (dev_addr_reg),
        .req            (in_data_reg),
        .res            (step_res)
    );

    assign res.valid       = out_valid_reg;
    assign res.scl_out     = out_data_reg.scl_out;
    assign res.sda_out     = out_data_reg.sda_out;
    assign res.busy_res    = out_data_reg.busy_res;
    assign res.done_res    = out_data_reg.done_res;
    assign res.read_data   = out_data_reg.read_data;
    assign res.error_code  = out_data_reg.error_code;
    assign res.error_place = out_data_reg.error_place;

`ifndef NO_ASSERTIONS
    a_adv_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("result register empty after a step");

    a_idle_lines_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.busy_res |->
            out_data_reg.scl_out && out_data_reg.sda_out)
        else $error("lines driven while idle");

    a_done_in_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.done_res |->
            out_data_reg.busy_res && !out_data_reg.scl_out && out_data_reg.sda_out)
        else $error("done outside the last stop phase");

    a_error_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_data_reg.error_code == i2cram_pkg::ERR_NONE) ==
             (out_data_reg.error_place == i2cram_pkg::PL_NONE)))
        else $error("error code and place disagree");
`endif

endmodule

### test/i2c_register_access_master_tb.sv
`timescale 1ns / 1ps

module i2c_register_access_master_tb;

    localparam logic [3:0] START_SCL = 4'b0111;
    localparam logic [3:0] START_SDA = 4'b0011;
    localparam logic [3:0] STOP_SCL  = 4'b0110;
    localparam logic [3:0] STOP_SDA  = 4'b1100;
    localparam logic [0:8][2:0] WRITE_PLAN =
        {i2cram_pkg::K_END, i2cram_pkg::K_START, i2cram_pkg::K_TXDW, i2cram_pkg::K_TXREG,
         i2cram_pkg::K_TXDAT, i2cram_pkg::K_STOP, i2cram_pkg::K_END, i2cram_pkg::K_END,
         i2cram_pkg::K_END};
    localparam logic [0:8][2:0] READ_PLAN =
        {i2cram_pkg::K_END, i2cram_pkg::K_START, i2cram_pkg::K_TXDW, i2cram_pkg::K_TXREG,
         i2cram_pkg::K_STOP, i2cram_pkg::K_START, i2cram_pkg::K_TXDR, i2cram_pkg::K_RX,
         i2cram_pkg::K_STOP};
    localparam int DRAIN_LIMIT = 5000;
    localparam int RANDOM_PHASE_TICKS = 80;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    i2cram_req_if req_ch ();
    i2cram_res_if res_ch ();

    i2c_register_access_master dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch)
    );

    always #6 clk = ~clk;

    // Model of the bus master, advanced once per accepted request.
    logic [6:0] dev_addr   = i2cram_pkg::DEV_ADDR_RESET;
    logic [2:0] ph_step    = 3'd0;
    logic [3:0] seg_idx    = 4'd0;
    logic [3:0] bit_cnt    = 4'd0;
    logic [7:0] shift_q    = 8'd0;
    logic       cur_op     = i2cram_pkg::OP_WRITE;
    logic [7:0] cur_reg    = 8'd0;
    logic [7:0] cur_data   = 8'd0;
    logic [7:0] rx_byte    = 8'd0;
    logic [2:0] pred_code  = i2cram_pkg::ERR_NONE;
    logic [2:0] pred_place = i2cram_pkg::PL_NONE;

    // What the target and the wires do with the lines.
    logic [1:0] last_drive     = 2'b11;
    logic       last_done      = 1'b0;
    logic [7:0] slave_byte     = 8'd0;
    logic [2:0] inject_place   = i2cram_pkg::PL_NONE;
    logic       inject_armed   = 1'b0;
    logic       inject_rx_only = 1'b0;
    int         noise_pct      = 0;

    i2cram_pkg::res_t expected_bus_phases [$];
    i2cram_pkg::res_t got;
    i2cram_pkg::res_t want;

    logic idle_on     = 1'b1;
    int   sink_hold   = 0;
    int   fail_count  = 0;
    int   checked     = 0;
    int   tick_count  = 0;
    int   transfer_ticks = 0;
    int   n_writes    = 0;
    int   n_reads     = 0;
    int   n_faulted   = 0;
    int   n_settings  = 0;

    function automatic logic sends_byte(logic [2:0] k);
        return k == i2cram_pkg::K_TXDW || k == i2cram_pkg::K_TXDR
            || k == i2cram_pkg::K_TXREG || k == i2cram_pkg::K_TXDAT;
    endfunction

    function automatic logic [2:0] seg_kind(logic [3:0] idx);
        if (idx < 4'd1 || idx > 4'd8)
            return i2cram_pkg::K_END;
        return cur_op == i2cram_pkg::OP_READ ? READ_PLAN[idx] : WRITE_PLAN[idx];
    endfunction

    function automatic void note_fault(logic [2:0] code, logic [2:0] place);
        if (pred_code == i2cram_pkg::ERR_NONE)
        begin
            pred_code = code;
            pred_place = place;
        end
    endfunction

    function automatic void open_segment(logic [3:0] idx);
        logic [2:0] k;
        k = seg_kind(idx);
        seg_idx = idx;
        ph_step = 3'd0;
        bit_cnt = 4'd0;
        shift_q = 8'd0;
        case (k)
            i2cram_pkg::K_TXDW:  shift_q = {dev_addr, 1'b0};
            i2cram_pkg::K_TXDR:  shift_q = {dev_addr, 1'b1};
            i2cram_pkg::K_TXREG: shift_q = cur_reg;
            i2cram_pkg::K_TXDAT: shift_q = cur_data;
            i2cram_pkg::K_END:   seg_idx = 4'd0;
            default: ;
        endcase
    endfunction

    function automatic logic [2:0] phase_len(logic [2:0] k);
        if (k == i2cram_pkg::K_START || k == i2cram_pkg::K_STOP)
            return 3'd4;
        if (sends_byte(k))
            return bit_cnt < i2cram_pkg::BITS_PER_BYTE ? 3'd3 : 3'd2;
        return bit_cnt < i2cram_pkg::BITS_PER_BYTE ? 3'd2 : 3'd3;
    endfunction

    function automatic void check_lines(logic [2:0] k, logic scl, logic sda);
        if (k == i2cram_pkg::K_STOP)
        begin
            if (ph_step == 3'd1 && !scl)
                note_fault(i2cram_pkg::ERR_CLK_LOW, i2cram_pkg::PL_STOP_CLK);
            if (ph_step == 3'd2 && !sda)
                note_fault(i2cram_pkg::ERR_STOP_DATA, i2cram_pkg::PL_STOP_DATA);
        end
        else if (sends_byte(k))
        begin
            if (bit_cnt < i2cram_pkg::BITS_PER_BYTE)
            begin
                if (ph_step == 3'd0 && shift_q[7] && !sda)
                    note_fault(i2cram_pkg::ERR_DATA_LOW, i2cram_pkg::PL_BITOUT_DAT);
                if (ph_step == 3'd1 && !scl)
                    note_fault(i2cram_pkg::ERR_CLK_LOW, i2cram_pkg::PL_BITOUT_CLK);
            end
            else if (ph_step == 3'd0)
            begin
                if (!scl) note_fault(i2cram_pkg::ERR_CLK_LOW, i2cram_pkg::PL_BITIN_CLK);
                if (sda) note_fault(i2cram_pkg::ERR_NO_ACK, i2cram_pkg::PL_ACK);
            end
        end
        else if (k == i2cram_pkg::K_RX)
        begin
            if (bit_cnt < i2cram_pkg::BITS_PER_BYTE)
            begin
                if (ph_step == 3'd0)
                begin
                    if (!scl) note_fault(i2cram_pkg::ERR_CLK_LOW, i2cram_pkg::PL_BITIN_CLK);
                    shift_q = {shift_q[6:0], sda};
                end
            end
            else
            begin
                if (ph_step == 3'd0 && !sda)
                    note_fault(i2cram_pkg::ERR_DATA_LOW, i2cram_pkg::PL_BITOUT_DAT);
                if (ph_step == 3'd1 && !scl)
                    note_fault(i2cram_pkg::ERR_CLK_LOW, i2cram_pkg::PL_BITOUT_CLK);
            end
        end
    endfunction

    function automatic void advance_phase(logic [2:0] k);
        if (sends_byte(k) && bit_cnt < i2cram_pkg::BITS_PER_BYTE && ph_step == 3'd2)
            shift_q = {shift_q[6:0], 1'b0};
        ph_step = ph_step + 3'd1;
        if (ph_step < phase_len(k))
            return;
        ph_step = 3'd0;
        if (sends_byte(k) || k == i2cram_pkg::K_RX)
        begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt <= i2cram_pkg::BITS_PER_BYTE)
                return;
            if (k == i2cram_pkg::K_RX)
                rx_byte = shift_q;
        end
        open_segment(seg_idx + 4'd1);
    endfunction

    function automatic logic [1:0] line_drive(logic [2:0] k);
        logic [1:0] p;
        p = ph_step[1:0];
        if (k == i2cram_pkg::K_START)
            return {START_SCL[p], START_SDA[p]};
        if (k == i2cram_pkg::K_STOP)
            return {STOP_SCL[p], STOP_SDA[p]};
        if (sends_byte(k))
            return bit_cnt < i2cram_pkg::BITS_PER_BYTE ? {p == 2'd1, shift_q[7]}
                                                       : {p == 2'd0, 1'b1};
        return bit_cnt < i2cram_pkg::BITS_PER_BYTE ? {p == 2'd0, 1'b1} : {p == 2'd1, 1'b1};
    endfunction

    function automatic i2cram_pkg::res_t step_master(i2cram_pkg::req_t item);
        i2cram_pkg::res_t r;
        logic [2:0] k;
        r = '0;
        r.scl_out = 1'b1;
        r.sda_out = 1'b1;
        if (seg_idx != 4'd0)
        begin
            k = seg_kind(seg_idx);
            if (k == i2cram_pkg::K_END)
                seg_idx = 4'd0;
            else
            begin
                check_lines(k, item.scl_level, item.sda_level);
                advance_phase(k);
            end
        end
        if (seg_idx == 4'd0 && item.start_request)
        begin
            cur_op = item.operation;
            cur_reg = item.reg_address;
            cur_data = item.write_data;
            pred_code = i2cram_pkg::ERR_NONE;
            pred_place = i2cram_pkg::PL_NONE;
            open_segment(4'd1);
        end
        if (seg_idx != 4'd0)
        begin
            k = seg_kind(seg_idx);
            {r.scl_out, r.sda_out} = line_drive(k);
            r.busy_res = 1'b1;
            r.done_res = k == i2cram_pkg::K_STOP && ph_step == 3'd3
                         && seg_kind(seg_idx + 4'd1) == i2cram_pkg::K_END;
        end
        r.read_data = rx_byte;
        r.error_code = pred_code;
        r.error_place = pred_place;
        return r;
    endfunction

    // Levels seen on the wires after the phase now being driven, with the
    // target acknowledging, returning its data byte, and faults laid on top.
    function automatic logic [1:0] bus_levels();
        logic [2:0] k;
        logic scl;
        logic sda;
        logic hit;
        if (seg_idx == 4'd0)
        begin
            scl = 1'($urandom_range(0, 1));
            sda = 1'($urandom_range(0, 1));
            return {scl, sda};
        end
        k = seg_kind(seg_idx);
        {scl, sda} = last_drive;
        hit = 1'b0;
        if (sends_byte(k) && bit_cnt == i2cram_pkg::BITS_PER_BYTE)
            sda = 1'b0;
        if (k == i2cram_pkg::K_RX && bit_cnt < i2cram_pkg::BITS_PER_BYTE)
            sda = slave_byte[3'd7 - bit_cnt[2:0]];
        if (inject_armed && (!inject_rx_only || k == i2cram_pkg::K_RX))
        begin
            case (inject_place)
                i2cram_pkg::PL_STOP_CLK:
                    if (k == i2cram_pkg::K_STOP && ph_step == 3'd1)
                    begin
                        scl = 1'b0;
                        hit = 1'b1;
                    end
                i2cram_pkg::PL_STOP_DATA:
                    if (k == i2cram_pkg::K_STOP && ph_step == 3'd2)
                    begin
                        sda = 1'b0;
                        hit = 1'b1;
                    end
                i2cram_pkg::PL_BITIN_CLK:
                    if (ph_step == 3'd0
                        && ((sends_byte(k) && bit_cnt == i2cram_pkg::BITS_PER_BYTE)
                            || (k == i2cram_pkg::K_RX
                                && bit_cnt < i2cram_pkg::BITS_PER_BYTE)))
                    begin
                        scl = 1'b0;
                        hit = 1'b1;
                    end
                i2cram_pkg::PL_BITOUT_DAT:
                    if (ph_step == 3'd0
                        && ((sends_byte(k) && bit_cnt < i2cram_pkg::BITS_PER_BYTE
                             && shift_q[7])
                            || (k == i2cram_pkg::K_RX
                                && bit_cnt == i2cram_pkg::BITS_PER_BYTE)))
                    begin
                        sda = 1'b0;
                        hit = 1'b1;
                    end
                i2cram_pkg::PL_BITOUT_CLK:
                    if (ph_step == 3'd1
                        && ((sends_byte(k) && bit_cnt < i2cram_pkg::BITS_PER_BYTE)
                            || (k == i2cram_pkg::K_RX
                                && bit_cnt == i2cram_pkg::BITS_PER_BYTE)))
                    begin
                        scl = 1'b0;
                        hit = 1'b1;
                    end
                i2cram_pkg::PL_ACK:
                    if (ph_step == 3'd0 && sends_byte(k)
                        && bit_cnt == i2cram_pkg::BITS_PER_BYTE)
                    begin
                        sda = 1'b1;
                        hit = 1'b1;
                    end
                default: ;
            endcase
            if (hit)
                inject_armed = 1'b0;
        end
        if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
            scl = ~scl;
        if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
            sda = ~sda;
        return {scl, sda};
    endfunction

    task automatic send_tick(i2cram_pkg::req_t item);
        i2cram_pkg::res_t r;
        if (idle_on && $urandom_range(0, 11) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.start_request <= item.start_request;
        req_ch.operation     <= item.operation;
        req_ch.reg_address   <= item.reg_address;
        req_ch.write_data    <= item.write_data;
        req_ch.scl_level     <= item.scl_level;
        req_ch.sda_level     <= item.sda_level;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        r = step_master(item);
        expected_bus_phases.push_back(r);
        last_drive = {r.scl_out, r.sda_out};
        last_done = r.done_res;
        tick_count++;
    endtask

    task automatic bus_tick(logic start, logic op, logic [7:0] reg_a, logic [7:0] data);
        i2cram_pkg::req_t item;
        logic [1:0] lv;
        lv = bus_levels();
        item.start_request = start;
        item.operation = op;
        item.reg_address = reg_a;
        item.write_data = data;
        item.scl_level = lv[1];
        item.sda_level = lv[0];
        send_tick(item);
    endtask

    task automatic idle_ticks(int n);
        repeat (n)
            bus_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
    endtask

    task automatic run_transfer(logic op, logic [7:0] reg_a, logic [7:0] data,
                                logic [7:0] rx_value, logic [2:0] place,
                                logic rx_only, int noise);
        slave_byte = rx_value;
        inject_place = place;
        inject_rx_only = rx_only;
        inject_armed = place != i2cram_pkg::PL_NONE;
        noise_pct = noise;
        bus_tick(1'b1, op, reg_a, data);
        transfer_ticks++;
        while (!last_done)
        begin
            bus_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     8'($urandom), 8'($urandom));
            transfer_ticks++;
        end
        inject_armed = 1'b0;
        noise_pct = 0;
        if (op == i2cram_pkg::OP_READ)
            n_reads++;
        else
            n_writes++;
        if (pred_code != i2cram_pkg::ERR_NONE)
            n_faulted++;
    endtask

    task automatic wait_drain(int limit);
        int n;
        n = 0;
        req_ch.valid <= 1'b0;
        while (expected_bus_phases.size() != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
        @(posedge clk);
    endtask

    task automatic program_device_address(logic [6:0] addr);
        while (seg_idx != 4'd0)
            idle_ticks(1);
        wait_drain(DRAIN_LIMIT);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_we <= 1'b0;
        dev_addr = addr;
        n_settings++;
        @(posedge clk);
    endtask

    task automatic test_idle_outputs();
        idle_ticks(4);
    endtask

    task automatic test_write_and_read();
        run_transfer(i2cram_pkg::OP_WRITE, 8'hFF, 8'h00, 8'h00, i2cram_pkg::PL_NONE, 1'b0, 0);
        run_transfer(i2cram_pkg::OP_READ, 8'h00, 8'hFF, 8'hFF, i2cram_pkg::PL_NONE, 1'b0, 0);
    endtask

    task automatic test_line_faults();
        for (int p = 1; p <= 6; p++)
            run_transfer(i2cram_pkg::OP_WRITE, 8'($urandom), 8'($urandom), 8'h00, 3'(p),
                         1'b0, 0);
        idle_ticks(3);
    endtask

    task automatic test_device_address();
        program_device_address(7'h00);
        run_transfer(i2cram_pkg::OP_READ, 8'h33, 8'h00, 8'h44, i2cram_pkg::PL_NONE, 1'b0, 0);
    endtask

    task automatic test_flow_control();
        idle_on = 1'b0;
        sink_hold = 60;
        run_transfer(i2cram_pkg::OP_READ, 8'hC3, 8'h3C, 8'h96, i2cram_pkg::PL_NONE, 1'b0, 0);
        wait_drain(DRAIN_LIMIT);
        idle_on = 1'b1;
    endtask

    task automatic random_transfer();
        logic       op;
        logic [2:0] place;
        logic       rx_only;
        int         noise;
        int         sel;
        op = 1'($urandom_range(0, 1));
        place = i2cram_pkg::PL_NONE;
        rx_only = 1'b0;
        noise = 0;
        sel = $urandom_range(0, 9);
        if (sel >= 7)
            place = 3'($urandom_range(1, 6));
        if (sel == 9)
            noise = $urandom_range(1, 5);
        if (op == i2cram_pkg::OP_READ
            && (place == i2cram_pkg::PL_BITIN_CLK || place == i2cram_pkg::PL_BITOUT_DAT
                || place == i2cram_pkg::PL_BITOUT_CLK))
            rx_only = 1'($urandom_range(0, 1));
        run_transfer(op, 8'($urandom), 8'($urandom), 8'($urandom), place, rx_only, noise);
    endtask

    task automatic test_random_traffic();
        int start_ticks;
        for (int p = 0; p < 2; p++)
        begin
            if (p == 0)
                program_device_address(7'h7F);
            else
                program_device_address(7'($urandom_range(0, 127)));
            idle_on = (p == 0);
            start_ticks = transfer_ticks;
            while (transfer_ticks - start_ticks < RANDOM_PHASE_TICKS)
            begin
                if ($urandom_range(0, 9) < 8)
                    random_transfer();
                else
                    idle_ticks($urandom_range(1, 4));
            end
        end
    endtask

    initial
    begin
        res_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
                res_ch.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = {res_ch.scl_out, res_ch.sda_out, res_ch.busy_res, res_ch.done_res,
                   res_ch.read_data, res_ch.error_code, res_ch.error_place};
            if (expected_bus_phases.size() == 0)
            begin
                if (fail_count < 10)
                    $display("Unexpected result at %0t ns: scl=%b sda=%b busy=%b done=%b",
                             $time, got.scl_out, got.sda_out, got.busy_res, got.done_res);
                fail_count++;
            end
            else
            begin
                want = expected_bus_phases.pop_front();
                checked++;
                if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out
                    || got.busy_res !== want.busy_res || got.done_res !== want.done_res
                    || got.read_data !== want.read_data
                    || got.error_code !== want.error_code
                    || got.error_place !== want.error_place)
                begin
                    if (fail_count < 10)
                    begin
                        $display("Mismatch on result %0d at %0t ns", checked, $time);
                        $display("  expected scl=%b sda=%b busy=%b done=%b rd=%h err=%0d/%0d",
                                 want.scl_out, want.sda_out, want.busy_res, want.done_res,
                                 want.read_data, want.error_code, want.error_place);
                        $display("  actual   scl=%b sda=%b busy=%b done=%b rd=%h err=%0d/%0d",
                                 got.scl_out, got.sda_out, got.busy_res, got.done_res,
                                 got.read_data, got.error_code, got.error_place);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Timed out with %0d results outstanding.", expected_bus_phases.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= 7'd0;
        req_ch.valid         <= 1'b0;
        req_ch.start_request <= 1'b0;
        req_ch.operation     <= i2cram_pkg::OP_WRITE;
        req_ch.reg_address   <= 8'd0;
        req_ch.write_data    <= 8'd0;
        req_ch.scl_level     <= 1'b1;
        req_ch.sda_level     <= 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_outputs();
        test_write_and_read();
        test_line_faults();
        test_device_address();
        test_flow_control();
        test_random_traffic();

        wait_drain(DRAIN_LIMIT);
        repeat (20) @(posedge clk);
        if (expected_bus_phases.size() != 0)
        begin
            $display("%0d expected results never arrived.", expected_bus_phases.size());
            fail_count++;
        end
        $display("Covered %0d phase requests: %0d register writes and %0d reads, %0d faulted.",
                 tick_count, n_writes, n_reads, n_faulted);
        $display("Used %0d device address settings and checked %0d results.",
                 n_settings, checked);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
rtl/i2cram_pkg.sv
rtl/i2cram_if.sv
rtl/i2cram_seq.sv
rtl/i2c_register_access_master.sv
test/i2c_register_access_master_tb.sv
